@@ design/lom_pkg.sv @@
// lom_pkg: shared types and codes for the limit order matcher
// no dependencies
package lom_pkg;

  localparam int IdW    = 32;
  localparam int PriceW = 16;
  localparam int QtyW   = 24;

  typedef logic [1:0] kind_t;
  localparam kind_t KindTrade   = 2'd0;
  localparam kind_t KindFilled  = 2'd1;
  localparam kind_t KindRested  = 2'd2;
  localparam kind_t KindDropped = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } entry_t;

  // per-side command from the sequencer to the cell row
  typedef struct packed {
    logic              pop;      // drop head, shift row up by one
    logic              dec;      // subtract dec_qty from head
    logic [QtyW-1:0]   dec_qty;
    logic              ins;      // insert new entry in sorted place
    logic              sell;     // ordering of this side: 1 ascending (asks)
    entry_t            new_entry;
  } row_cmd_t;

  typedef struct packed {
    logic [IdW-1:0]    order_id;
    logic              order_side;
    logic [PriceW-1:0] limit_price;
    logic [QtyW-1:0]   order_qty;
  } order_t;

  typedef struct packed {
    kind_t             kind;
    logic [IdW-1:0]    maker_id;
    logic [IdW-1:0]    taker_id;
    logic [PriceW-1:0] trade_price;
    logic [QtyW-1:0]   trade_qty;
    logic              last;
  } result_t;

endpackage

@@ design/lom_if.sv @@
// lom_if: valid/ready channel carrying one payload item
// depends on lom_pkg for payload types
interface lom_order_if;
  logic            valid;
  logic            ready;
  lom_pkg::order_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lom_result_if;
  logic             valid;
  logic             ready;
  lom_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/lom_cell.sv @@
// lom_cell: one book slot; shifts toward head on pop, toward tail on insert
// depends on lom_pkg
module lom_cell (
  input  logic                clk,
  input  lom_pkg::row_cmd_t   cmd,
  input  logic                is_head,
  input  logic                occupied,
  input  logic                prev_occupied,
  input  logic                prev_ins_here,   // insert point is at or before prev
  input  lom_pkg::entry_t     prev_entry,
  input  lom_pkg::entry_t     next_entry,
  output lom_pkg::entry_t     entry,
  output logic                ins_here         // insert lands at or before this
);

  logic goes_before;
  lom_pkg::entry_t entry_next;

  // row is kept sorted, so the local test is already monotonic along the row
  always_comb begin
    if (cmd.sell) begin
      goes_before = cmd.new_entry.price < entry.price;
    end else begin
      goes_before = cmd.new_entry.price > entry.price;
    end
    ins_here = !occupied || goes_before;
  end

  always_comb begin
    entry_next = entry;
    if (cmd.pop) begin
      entry_next = next_entry;
    end else if (cmd.dec && is_head) begin
      entry_next.qty = entry.qty - cmd.dec_qty;
    end else if (cmd.ins && ins_here) begin
      if (prev_ins_here && prev_occupied) begin
        entry_next = prev_entry;
      end else if (!prev_ins_here) begin
        entry_next = cmd.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ design/lom_row.sv @@
// lom_row: one side of the book as a chain of lom_cell slots with a count
// depends on lom_pkg, lom_cell
module lom_row #(
  parameter int Depth = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  lom_pkg::row_cmd_t cmd,
  output lom_pkg::entry_t   head,
  output logic              empty,
  output logic              full
);

  localparam int CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count;
  lom_pkg::entry_t ents [Depth];
  logic [Depth-1:0] ins_at;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    lom_pkg::entry_t prev_e, next_e;
    logic prev_occ, prev_ins;
    if (i == 0) begin : g_first
      assign prev_e   = cmd.new_entry;
      assign prev_occ = 1'b0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_e   = ents[i-1];
      assign prev_occ = CntW'(i - 1) < count;
      assign prev_ins = ins_at[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_e = ents[i];
    end else begin : g_notlast
      assign next_e = ents[i+1];
    end
    lom_cell u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .is_head       (i == 0),
      .occupied      (CntW'(i) < count),
      .prev_occupied (prev_occ),
      .prev_ins_here (prev_ins),
      .prev_entry    (prev_e),
      .next_entry    (next_e),
      .entry         (ents[i]),
      .ins_here      (ins_at[i])
    );
  end

  assign head  = ents[0];
  assign empty = count == '0;
  assign full  = count == CntW'(Depth);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pop) begin
      count <= count - CntW'(1);
    end else if (cmd.ins) begin
      count <= count + CntW'(1);
    end
  end

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !empty) else $error("pop on empty side");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> !full) else $error("insert on full side");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && (cmd.pop || cmd.dec))) else $error("insert mixed with fill");
`endif

endmodule

@@ design/limit_order_matcher.sv @@
// limit_order_matcher: price-time priority matcher over two chains of book cells
// result items are registered: the trades first, then one status item marked last
// a new order is taken only in Idle; Match waits while the result side stalls
// each unstalled cycle the sequencer fills against the head of the opposite chain
// reset (rst, synchronous) empties both sides; book contents are not cleared
// depends on lom_pkg, lom_if, lom_row
module limit_order_matcher #(
  parameter int BOOK_DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  lom_order_if.sink  order_in,
  lom_result_if.source result_out
);

  typedef enum logic [1:0] {Idle, Match, Finish} state_t;

  state_t               state;
  lom_pkg::order_t      ord;
  lom_pkg::row_cmd_t    ask_cmd, bid_cmd;
  lom_pkg::entry_t      ask_head, bid_head, opp_head;
  logic                 ask_empty, bid_empty, ask_full, bid_full;
  logic                 opp_empty, own_full, crosses, out_free;
  logic [lom_pkg::QtyW-1:0] fill;
  lom_pkg::row_cmd_t    opp_cmd, own_cmd;

  lom_row #(.Depth(BOOK_DEPTH)) u_ask (
    .clk(clk), .rst(rst), .cmd(ask_cmd), .head(ask_head),
    .empty(ask_empty), .full(ask_full)
  );
  lom_row #(.Depth(BOOK_DEPTH)) u_bid (
    .clk(clk), .rst(rst), .cmd(bid_cmd), .head(bid_head),
    .empty(bid_empty), .full(bid_full)
  );

  assign out_free  = !result_out.valid || result_out.ready;
  assign opp_head  = ord.order_side ? bid_head : ask_head;
  assign opp_empty = ord.order_side ? bid_empty : ask_empty;
  assign own_full  = ord.order_side ? ask_full : bid_full;
  assign crosses   = ord.order_side ? (opp_head.price >= ord.limit_price)
                                    : (opp_head.price <= ord.limit_price);
  assign fill      = (ord.order_qty < opp_head.qty) ? ord.order_qty : opp_head.qty;

  logic do_fill, fill_done;
  assign fill_done = ord.order_qty == '0 || opp_empty || !crosses;
  assign do_fill   = state == Match && out_free && !fill_done;

  always_comb begin
    opp_cmd = '0;
    own_cmd = '0;
    opp_cmd.sell = !ord.order_side;
    own_cmd.sell = ord.order_side;
    own_cmd.new_entry.id    = ord.order_id;
    own_cmd.new_entry.price = ord.limit_price;
    own_cmd.new_entry.qty   = ord.order_qty;
    opp_cmd.new_entry       = own_cmd.new_entry;
    if (do_fill) begin
      opp_cmd.pop     = fill == opp_head.qty;
      opp_cmd.dec     = fill != opp_head.qty;
      opp_cmd.dec_qty = fill;
    end
    if (state == Match && out_free && fill_done && ord.order_qty != '0 && !own_full) begin
      own_cmd.ins = 1'b1;
    end
    ask_cmd = ord.order_side ? own_cmd : opp_cmd;
    bid_cmd = ord.order_side ? opp_cmd : own_cmd;
  end

  assign order_in.ready = state == Idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      result_out.valid <= 1'b0;
    end else begin
      if (result_out.ready && !(state == Match && out_free)) begin
        result_out.valid <= 1'b0;
      end
      case (state)
        Idle: begin
          if (order_in.valid) begin
            ord   <= order_in.payload;
            state <= Match;
          end
        end
        Match: begin
          if (out_free) begin
            result_out.valid <= 1'b1;
            result_out.payload.taker_id <= ord.order_id;
            if (!fill_done) begin
              result_out.payload.kind        <= lom_pkg::KindTrade;
              result_out.payload.maker_id    <= opp_head.id;
              result_out.payload.trade_price <= opp_head.price;
              result_out.payload.trade_qty   <= fill;
              result_out.payload.last        <= 1'b0;
              ord.order_qty <= ord.order_qty - fill;
            end else begin
              result_out.payload.maker_id    <= '0;
              result_out.payload.trade_price <= ord.limit_price;
              result_out.payload.trade_qty   <= ord.order_qty;
              result_out.payload.last        <= 1'b1;
              if (ord.order_qty == '0) begin
                result_out.payload.kind <= lom_pkg::KindFilled;
              end else if (own_full) begin
                result_out.payload.kind <= lom_pkg::KindDropped;
              end else begin
                result_out.payload.kind <= lom_pkg::KindRested;
              end
              state <= Finish;
            end
          end
        end
        Finish: begin
          state <= Idle;
        end
        default: state <= Idle;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (order_in.valid && order_in.ready) |=> state == Match)
    else $error("accepted item did not start matching");
  a_fill_emits: assert property (@(posedge clk) disable iff (rst)
    do_fill |=> (result_out.valid && result_out.payload.kind == lom_pkg::KindTrade))
    else $error("fill without trade item");
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == Finish) |-> (result_out.valid && result_out.payload.last))
    else $error("status item missing at finish");
`endif

endmodule

@@ sim/lom_checker.sv @@
// lom_checker: watches the order and result channels of the limit order matcher,
// keeps its own two-sided book and compares every result item against it
// depends on lom_pkg and lom_if
module lom_checker #(
  parameter int BOOK_DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  lom_order_if       order_ch,
  lom_result_if      result_ch,
  output int         fail_count,
  output int         pending,
  output int         orders_seen,
  output int         results_seen,
  output int         trades_seen,
  output int         drops_seen
);

  lom_pkg::entry_t ask_side[$];
  lom_pkg::entry_t bid_side[$];
  lom_pkg::result_t expected_fills[$];

  task automatic match_order(input lom_pkg::order_t o);
    logic [lom_pkg::QtyW-1:0] left;
    logic [lom_pkg::QtyW-1:0] fill;
    lom_pkg::entry_t head;
    lom_pkg::entry_t rest;
    lom_pkg::result_t r;
    int pos;
    left = o.order_qty;
    while (left != 0) begin
      if (o.order_side) begin
        if (bid_side.size() == 0 || bid_side[0].price < o.limit_price) break;
        head = bid_side[0];
      end else begin
        if (ask_side.size() == 0 || ask_side[0].price > o.limit_price) break;
        head = ask_side[0];
      end
      fill = (left < head.qty) ? left : head.qty;
      r = '{lom_pkg::KindTrade, head.id, o.order_id, head.price, fill, 1'b0};
      expected_fills.insert(expected_fills.size(), r);
      left -= fill;
      head.qty -= fill;
      if (o.order_side) begin
        if (head.qty == 0) bid_side.delete(0);
        else bid_side[0] = head;
      end else begin
        if (head.qty == 0) ask_side.delete(0);
        else ask_side[0] = head;
      end
    end
    r = '{lom_pkg::KindFilled, '0, o.order_id, o.limit_price, left, 1'b1};
    if (left != 0) begin
      rest = '{o.order_id, o.limit_price, left};
      if (o.order_side) begin
        if (ask_side.size() >= BOOK_DEPTH) r.kind = lom_pkg::KindDropped;
        else begin
          r.kind = lom_pkg::KindRested;
          pos = 0;
          while (pos < ask_side.size() && ask_side[pos].price <= o.limit_price) pos++;
          ask_side.insert(pos, rest);
        end
      end else begin
        if (bid_side.size() >= BOOK_DEPTH) r.kind = lom_pkg::KindDropped;
        else begin
          r.kind = lom_pkg::KindRested;
          pos = 0;
          while (pos < bid_side.size() && bid_side[pos].price >= o.limit_price) pos++;
          bid_side.insert(pos, rest);
        end
      end
    end
    expected_fills.insert(expected_fills.size(), r);
  endtask

  always @(posedge clk) begin
    lom_pkg::result_t want;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      orders_seen <= 0;
      results_seen <= 0;
      trades_seen <= 0;
      drops_seen <= 0;
      ask_side.delete();
      bid_side.delete();
      expected_fills.delete();
    end else begin
      if (order_ch.valid && order_ch.ready) begin
        match_order(order_ch.payload);
        orders_seen <= orders_seen + 1;
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen <= results_seen + 1;
        if (result_ch.payload.kind == lom_pkg::KindTrade) trades_seen <= trades_seen + 1;
        if (result_ch.payload.kind == lom_pkg::KindDropped) drops_seen <= drops_seen + 1;
        if (expected_fills.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result item: %p", result_ch.payload);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fills[0];
          expected_fills.delete(0);
          if (result_ch.payload !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %p actual %p", want, result_ch.payload);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_fills.size();
    end
  end
endmodule

@@ sim/limit_order_matcher_test.sv @@
// limit_order_matcher_test: drives orders into the matcher with bursty timing and
// a stalling result sink; verdict taken from lom_checker
// depends on lom_pkg, lom_if, limit_order_matcher and lom_checker
module limit_order_matcher_test;

  localparam int Depth = 32;
  localparam int RandomOrders = 420;
  localparam int IdleLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending, orders_seen, results_seen, trades_seen, drops_seen;
  int idle_cycles = 0;
  int stall_mode = 0;
  logic [31:0] next_id = 32'd1;

  lom_order_if  order_ch ();
  lom_result_if result_ch ();

  limit_order_matcher #(.BOOK_DEPTH(Depth)) uut (
    .clk(clk), .rst(rst), .order_in(order_ch.sink), .result_out(result_ch.source)
  );

  lom_checker #(.BOOK_DEPTH(Depth)) check (
    .clk(clk), .rst(rst), .order_ch(order_ch), .result_ch(result_ch),
    .fail_count(fail_count), .pending(pending), .orders_seen(orders_seen),
    .results_seen(results_seen), .trades_seen(trades_seen), .drops_seen(drops_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: phases of always ready, random, and mostly stalled
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= 1'($urandom_range(0, 1));
      default: result_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (order_ch.valid && order_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_order(input logic [31:0] id, input logic side,
                            input logic [15:0] price, input logic [23:0] qty);
    order_ch.valid <= 1'b1;
    order_ch.payload <= '{id, side, price, qty};
    @(posedge clk);
    while (!order_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    order_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic send_near(input logic side, input int mid);
    int p;
    p = mid + $signed($urandom_range(0, 16)) - 8;
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    send_order(next_id, side, p[15:0],
      24'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                      : $urandom_range(1, 300)));
    next_id = next_id + 1;
  endtask

  initial begin
    int burst;
    int mid;
    order_ch.valid = 1'b0;
    order_ch.payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, crossing, partial fill, equal price ordering, full side
    send_order(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 24'hFFFFFF);
    send_order(32'h0000_0000, 1'b0, 16'h0000, 24'd1);
    send_order(32'hA5A5_A5A5, 1'b0, 16'hFFFF, 24'd10);
    send_order(32'h5A5A_5A5A, 1'b1, 16'h0000, 24'd5);
    send_order(32'd10, 1'b1, 16'd100, 24'd50);
    send_order(32'd11, 1'b1, 16'd100, 24'd60);
    send_order(32'd12, 1'b1, 16'd99, 24'd7);
    send_order(32'd13, 1'b0, 16'd100, 24'd80);
    send_order(32'd14, 1'b0, 16'd200, 24'd200);
    send_order(32'd15, 1'b1, 16'd1, 24'd500);
    // bids until the side overflows, then one sell sweeping the whole side
    for (int i = 0; i < 42; i++)
      send_order(32'(100 + i), 1'b0, 16'(10 + i), 24'(40 + i));
    send_order(32'd200, 1'b1, 16'd0, 24'hFFFFFF);
    order_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    mid = 1000;
    for (int n = 0; n < RandomOrders; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < RandomOrders; b++, n++) begin
        if ($urandom_range(0, 19) == 0)
          send_order($urandom, 1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom));
        else begin
          send_near(1'($urandom_range(0, 1)), mid);
          if ($urandom_range(0, 49) == 0) mid = $urandom_range(100, 65400);
        end
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    order_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered %0d orders, %0d result items, %0d trades, %0d dropped remainders",
             orders_seen, results_seen, trades_seen, drops_seen);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
